// ===== rtl/bpg_pkg.sv =====
package bpg_pkg;

  // Grid subdivisions per triangle edge and coordinate width (signed Q16.16).
  localparam int SUBDIVISIONS = 8;
  localparam int COORD_WIDTH  = 32;

  // Fraction bits of a coordinate and of a weight.
  localparam int FRAC_BITS = 16;
  // A weight runs from 0 to 1.0 inclusive, so it needs one bit above the fraction.
  localparam int WEIGHT_W  = FRAC_BITS + 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_BITS);

  // Grid index width.
  localparam int INDEX_W = $clog2(SUBDIVISIONS + 1);

  // Floored product of a coordinate and a weight, and the sum of three of them.
  localparam int PROD_W = COORD_WIDTH + WEIGHT_W + 1 - FRAC_BITS;
  localparam int SUM_W  = PROD_W + 2;

  // Points emitted per triangle: the full grid less its three corners.
  localparam int POINT_COUNT = (SUBDIVISIONS + 1) * (SUBDIVISIONS + 2) / 2 - 3;
  localparam bit HAS_POINTS  = POINT_COUNT > 0;

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic [WEIGHT_W-1:0]    weight_t;
  typedef logic [INDEX_W-1:0]     index_t;
  typedef logic [SUBDIVISIONS:0][WEIGHT_W-1:0] weight_tab_t;

  // One grid point leaving the sequencer: its three barycentric weights.
  typedef struct packed {
    logic    valid;
    logic    last;
    weight_t w0;
    weight_t w1;
    weight_t w2;
  } bpg_pt_t;

  // Control that travels alongside the lane data.
  typedef struct packed {
    logic valid;
    logic last;
  } bpg_ctl_t;

  // k / N in Q1.16, floored, for every grid index k.
  function automatic weight_tab_t build_weights();
    weight_tab_t tab;
    for (int k = 0; k <= SUBDIVISIONS; k++) begin
      tab[k] = WEIGHT_W'((k * (1 << FRAC_BITS)) / SUBDIVISIONS);
    end
    return tab;
  endfunction

  localparam weight_tab_t WEIGHT_TAB = build_weights();

endpackage

// ===== rtl/triangle_barycentric_point_grid_unit.sv =====
// Barycentric point grid over one triangle. Each accepted item is a triangle
// given as three vertices a, b and c in signed Q16.16. The unit returns the
// points (1-e-h)*a + e*b + h*c of a regular grid with SUBDIVISIONS steps per
// edge (e = i/N on the outer index, h = j/N on the inner index, j running
// fastest), leaving out the three corners, and raises last_point on the final
// point of the triangle. At the default of eight subdivisions a triangle
// yields 42 points. The grid sequencer issues one point per cycle while the
// output does not stall. Once the last point of a triangle is issued, the
// sequencer leaves its busy state and can take the next triangle, whose
// first point is issued in the same cycle that the triangle is taken, which
// keeps the output stream gapless. Three axis lanes, one each for x, y and
// z, multiply the coordinates by the Q1.16 weights (products floored toward
// minus infinity) and add them, and a merging stage clips each sum to the
// signed coordinate range and registers the point. A triangle's first point
// passes the sequencer's point register, the lane product and sum registers
// and the merge register. A stall on a valid output freezes the whole pipeline.
module triangle_barycentric_point_grid_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bpg_pkg::COORD_WIDTH-1:0]    a_x,
  input  logic [bpg_pkg::COORD_WIDTH-1:0]    a_y,
  input  logic [bpg_pkg::COORD_WIDTH-1:0]    a_z,
  input  logic [bpg_pkg::COORD_WIDTH-1:0]    b_x,
  input  logic [bpg_pkg::COORD_WIDTH-1:0]    b_y,
  input  logic [bpg_pkg::COORD_WIDTH-1:0]    b_z,
  input  logic [bpg_pkg::COORD_WIDTH-1:0]    c_x,
  input  logic [bpg_pkg::COORD_WIDTH-1:0]    c_y,
  input  logic [bpg_pkg::COORD_WIDTH-1:0]    c_z,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bpg_pkg::COORD_WIDTH-1:0]    pt_x,
  output logic [bpg_pkg::COORD_WIDTH-1:0]    pt_y,
  output logic [bpg_pkg::COORD_WIDTH-1:0]    pt_z,
  output logic                               last_point
);
  import bpg_pkg::*;

  // The pipeline moves whenever the output register is free or being drained.
  logic adv;

  logic [8:0][COORD_WIDTH-1:0] vin;
  logic [8:0][COORD_WIDTH-1:0] vtx;
  bpg_pt_t                     seq_pt;
  bpg_ctl_t                    ctl_mul, ctl_sum;
  logic [2:0][SUM_W-1:0]       lane_sum;
  logic [2:0][COORD_WIDTH-1:0] out_pt;

  assign adv = !(out_valid && out_stall);

  // The vertex store is laid out as a, b, c with x, y, z inside each vertex.
  assign vin = {c_z, c_y, c_x, b_z, b_y, b_x, a_z, a_y, a_x};

  bpg_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .vin      (vin),
    .vtx      (vtx),
    .pt       (seq_pt)
  );

  // Valid and last flags follow the lane data through its two stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mul <= '0;
      ctl_sum <= '0;
    end else if (adv) begin
      ctl_mul <= '{valid: seq_pt.valid, last: seq_pt.last};
      ctl_sum <= ctl_mul;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    bpg_lane u_lane (
      .clk (clk),
      .adv (adv),
      .pt  (seq_pt),
      .ca  ($signed(vtx[k])),
      .cb  ($signed(vtx[3 + k])),
      .cc  ($signed(vtx[6 + k])),
      .sum (lane_sum[k])
    );
  end

  bpg_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .ctl   (ctl_sum),
    .sums  (lane_sum),
    .valid (out_valid),
    .pt    (out_pt),
    .last  (last_point)
  );

  assign pt_x = out_pt[0];
  assign pt_y = out_pt[1];
  assign pt_z = out_pt[2];

endmodule

// ===== rtl/bpg_seq.sv =====
module bpg_seq (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [8:0][bpg_pkg::COORD_WIDTH-1:0] vin,
  output logic [8:0][bpg_pkg::COORD_WIDTH-1:0] vtx,
  output bpg_pkg::bpg_pt_t                     pt
);
  import bpg_pkg::*;

  logic    busy, busy_next;
  index_t  row, row_next;
  index_t  col, col_next;
  bpg_pt_t pt_next;
  index_t  cur_i, cur_j;
  logic    accept, emit, cur_last;

  assign in_stall = busy || !adv;
  assign accept   = in_valid && !busy && adv;
  assign emit     = adv && (busy || (accept && HAS_POINTS));

  // An idle sequencer starts a new triangle at the first non-corner point (0,1).
  assign cur_i    = busy ? row : '0;
  assign cur_j    = busy ? col : index_t'(1);
  assign cur_last = (cur_i == index_t'(SUBDIVISIONS - 1)) && (cur_j == index_t'(1));

  always_comb begin
    busy_next = busy;
    row_next  = row;
    col_next  = col;
    pt_next   = pt;
    if (adv) begin
      pt_next.valid = emit;
      pt_next.last  = cur_last;
      pt_next.w1    = WEIGHT_TAB[cur_i];
      pt_next.w2    = WEIGHT_TAB[cur_j];
      pt_next.w0    = WEIGHT_ONE - WEIGHT_TAB[cur_i] - WEIGHT_TAB[cur_j];
      if (emit) begin
        busy_next = !cur_last;
        if (cur_i == '0 && cur_j == index_t'(SUBDIVISIONS - 1)) begin
          // The top corner of the first row is skipped.
          row_next = index_t'(1);
          col_next = '0;
        end else if (cur_j == index_t'(SUBDIVISIONS) - cur_i) begin
          row_next = cur_i + index_t'(1);
          col_next = '0;
        end else begin
          row_next = cur_i;
          col_next = cur_j + index_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      row      <= '0;
      col      <= '0;
      pt.valid <= 1'b0;
    end else begin
      busy     <= busy_next;
      row      <= row_next;
      col      <= col_next;
      pt.valid <= pt_next.valid;
    end
    pt.last <= pt_next.last;
    pt.w0   <= pt_next.w0;
    pt.w1   <= pt_next.w1;
    pt.w2   <= pt_next.w2;
    if (accept) begin
      vtx <= vin;
    end
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (busy && adv && cur_last) |=> !busy)
    else $error("sequencer still busy after the last point");

  a_weights_sum_one: assert property (@(posedge clk) disable iff (rst)
    pt.valid |-> ((WEIGHT_W + 2)'(pt.w0) + (WEIGHT_W + 2)'(pt.w1) + (WEIGHT_W + 2)'(pt.w2)
                  == (WEIGHT_W + 2)'(WEIGHT_ONE)))
    else $error("barycentric weights do not sum to one");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (pt.valid && !adv) |=> (pt.valid && $stable(pt)))
    else $error("grid point changed while the pipeline was held");

endmodule

// ===== rtl/bpg_lane.sv =====
module bpg_lane (
  input  logic                                  clk,
  input  logic                                  adv,
  input  bpg_pkg::bpg_pt_t                      pt,
  input  logic signed [bpg_pkg::COORD_WIDTH-1:0] ca,
  input  logic signed [bpg_pkg::COORD_WIDTH-1:0] cb,
  input  logic signed [bpg_pkg::COORD_WIDTH-1:0] cc,
  output logic signed [bpg_pkg::SUM_W-1:0]      sum
);
  import bpg_pkg::*;

  logic signed [COORD_WIDTH+WEIGHT_W:0] full_a, full_b, full_c;
  logic signed [PROD_W-1:0]             prod_a, prod_b, prod_c;

  // Each weight is non-negative, so it enters the signed multiply with a zero on top.
  assign full_a = ca * $signed({1'b0, pt.w0});
  assign full_b = cb * $signed({1'b0, pt.w1});
  assign full_c = cc * $signed({1'b0, pt.w2});

  // Dropping the fraction bits of a two's-complement product floors it.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_a <= full_a[COORD_WIDTH+WEIGHT_W:FRAC_BITS];
      prod_b <= full_b[COORD_WIDTH+WEIGHT_W:FRAC_BITS];
      prod_c <= full_c[COORD_WIDTH+WEIGHT_W:FRAC_BITS];
      sum    <= SUM_W'(prod_a) + SUM_W'(prod_b) + SUM_W'(prod_c);
    end
  end

endmodule

// ===== rtl/bpg_merge.sv =====
module bpg_merge (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  bpg_pkg::bpg_ctl_t                    ctl,
  input  logic [2:0][bpg_pkg::SUM_W-1:0]       sums,
  output logic                                 valid,
  output logic [2:0][bpg_pkg::COORD_WIDTH-1:0] pt,
  output logic                                 last
);
  import bpg_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_MAX =
    {{(SUM_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN =
    {{(SUM_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

  logic [2:0][COORD_WIDTH-1:0] clipped;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if ($signed(sums[k]) > SAT_MAX) begin
        clipped[k] = SAT_MAX[COORD_WIDTH-1:0];
      end else if ($signed(sums[k]) < SAT_MIN) begin
        clipped[k] = SAT_MIN[COORD_WIDTH-1:0];
      end else begin
        clipped[k] = sums[k][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pt   <= clipped;
      last <= ctl.last;
    end
  end

endmodule

// ===== tb/triangle_barycentric_point_grid_unit_tb.sv =====
// Self-checking testbench for triangle_barycentric_point_grid_unit.
//
// Each item sent to the unit is one triangle, given as nine signed Q16.16
// coordinates. For every accepted triangle the testbench works out the full
// list of grid points the unit should return and appends it to a queue.
// A monitor then takes every point that leaves the unit and compares it,
// field by field, with the oldest point in that queue.
module triangle_barycentric_point_grid_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpg_pkg::*;

  // Nine coordinates of one triangle: a_x, a_y, a_z, b_x, ... c_z, from slot 0 up.
  typedef logic [8:0][COORD_WIDTH-1:0] triangle_t;

  // One grid point as it should appear on the output ports.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } grid_point_t;

  localparam int     CLK_PERIOD   = 12;
  localparam int     RESET_CYCLES = 11;
  // Length of the long output hold that makes the unit back up into its input.
  localparam int     HOLD_CYCLES  = 400;
  // The first point passes the sequencer, lane and merge registers; allow a margin.
  localparam int     DRAIN_CYCLES = 16;
  // Slowest correct run: 480 triangles of 42 points, each waiting out the longest
  // random stall, plus sender gaps and the long hold. This is several times that.
  localparam int     LIMIT_CYCLES = 800_000;
  localparam coord_t MAX_COORD    = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t MIN_COORD    = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t ONE_Q16      = coord_t'(1) << FRAC_BITS;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  coord_t a_x = '0, a_y = '0, a_z = '0;
  coord_t b_x = '0, b_y = '0, b_z = '0;
  coord_t c_x = '0, c_y = '0, c_z = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t pt_x, pt_y, pt_z;
  logic   last_point;

  // Points that the unit still owes us, oldest first.
  grid_point_t pending_points[$];

  int  mismatch_count     = 0;
  int  triangles_sent     = 0;
  int  points_checked     = 0;
  int  input_stall_cycles = 0;

  // Control shared between the test tasks and the output stall process.
  bit  sender_gaps   = 1'b1;
  bit  stall_quiet   = 1'b0;
  bit  hold_request  = 1'b0;

  triangle_barycentric_point_grid_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .a_x        (a_x),
    .a_y        (a_y),
    .a_z        (a_z),
    .b_x        (b_x),
    .b_y        (b_y),
    .b_z        (b_z),
    .c_x        (c_x),
    .c_y        (c_y),
    .c_z        (c_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pt_x       (pt_x),
    .pt_y       (pt_y),
    .pt_z       (pt_z),
    .last_point (last_point)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the unit hangs or loses points.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

  // One coordinate of an interpolated point: the three weighted terms are each
  // floored to Q16.16 (an arithmetic right shift floors toward minus infinity),
  // added exactly, and clipped to the signed coordinate range.
  function automatic coord_t blend_coord(coord_t p0, coord_t p1, coord_t p2,
                                         int unsigned w0, int unsigned w1,
                                         int unsigned w2);
    longint acc;
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
    lo_lim = -hi_lim - 1;
    acc = (longint'($signed(p0)) * longint'(w0)) >>> FRAC_BITS;
    acc += (longint'($signed(p1)) * longint'(w1)) >>> FRAC_BITS;
    acc += (longint'($signed(p2)) * longint'(w2)) >>> FRAC_BITS;
    if (acc > hi_lim) acc = hi_lim;
    if (acc < lo_lim) acc = lo_lim;
    return coord_t'(acc);
  endfunction

  // Queue every point of the grid over one triangle in the order the unit
  // emits them: outer index i weights vertex b, inner index j weights vertex c,
  // j runs fastest, and the three corners are left out. The final point of the
  // triangle is (N-1, 1), which is where last_point must be raised.
  function automatic void predict_grid_points(triangle_t verts);
    int unsigned n;
    int unsigned w_b;
    int unsigned w_c;
    int unsigned w_a;
    grid_point_t pt;
    n = SUBDIVISIONS;
    for (int unsigned i = 0; i <= n; i++) begin
      for (int unsigned j = 0; j <= n - i; j++) begin
        if ((i == 0 && j == 0) || (i == 0 && j == n) || (i == n && j == 0)) continue;
        w_b = (i << FRAC_BITS) / n;
        w_c = (j << FRAC_BITS) / n;
        w_a = (1 << FRAC_BITS) - w_b - w_c;
        pt.x = blend_coord(verts[0], verts[3], verts[6], w_a, w_b, w_c);
        pt.y = blend_coord(verts[1], verts[4], verts[7], w_a, w_b, w_c);
        pt.z = blend_coord(verts[2], verts[5], verts[8], w_a, w_b, w_c);
        pt.last = (i == n - 1) && (j == 1);
        pending_points.insert(pending_points.size(), pt);
      end
    end
  endfunction

  // Offer one triangle and hold it until the unit takes it. Called right after
  // a rising edge; in_valid stays high on return so that back-to-back items
  // leave no gap on the input, and stop_sending lowers it.
  task automatic send_triangle(triangle_t verts);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    a_x <= verts[0];
    a_y <= verts[1];
    a_z <= verts[2];
    b_x <= verts[3];
    b_y <= verts[4];
    b_z <= verts[5];
    c_x <= verts[6];
    c_y <= verts[7];
    c_z <= verts[8];
    do @(posedge clk); while (in_stall);
    predict_grid_points(verts);
    triangles_sent++;
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Triangle with every axis of a vertex set to the same value.
  function automatic triangle_t flat_triangle(coord_t a, coord_t b, coord_t c);
    return {c, c, c, b, b, b, a, a, a};
  endfunction

  // Coordinates drawn from several ranges: the full word, a band around the
  // origin for well-shaped triangles, values at the extremes and whole numbers 0..255.
  function automatic coord_t random_coord();
    case ($urandom_range(0, 7)) inside
      [0:2]:   return coord_t'($urandom);
      [3:4]:   return coord_t'($urandom_range(0, 32'h00FF_FFFF)) - coord_t'(32'h0080_0000);
      5:       return MAX_COORD - coord_t'($urandom_range(0, 3));
      6:       return MIN_COORD + coord_t'($urandom_range(0, 3));
      default: return coord_t'($urandom_range(0, 255)) << FRAC_BITS;
    endcase
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t verts;
    for (int k = 0; k < 9; k++) verts[k] = random_coord();
    return verts;
  endfunction

  // Extremes of the coordinate range, mixed signs, values whose low bits make
  // the floored products lose a fraction, and a small triangle with coordinates of 0 and 1.0 or -1.0.
  task automatic test_corner_triangles();
    triangle_t unit_tri;
    send_triangle(flat_triangle('0, '0, '0));
    send_triangle(flat_triangle(MAX_COORD, MAX_COORD, MAX_COORD));
    send_triangle(flat_triangle(MIN_COORD, MIN_COORD, MIN_COORD));
    send_triangle(flat_triangle(MAX_COORD, MIN_COORD, MAX_COORD));
    send_triangle(flat_triangle(MIN_COORD, MAX_COORD, MIN_COORD));
    send_triangle(flat_triangle('0, MAX_COORD, MIN_COORD));
    send_triangle(flat_triangle('1, '1, '1));
    send_triangle(flat_triangle(coord_t'(1), '1, coord_t'(32'h0000_FFFF)));
    // Just above the most negative value, where the sum sits on the lower clip.
    send_triangle(flat_triangle(MIN_COORD + 1, MIN_COORD + coord_t'(32'h7FFF),
                                MIN_COORD + coord_t'(32'hFFFF)));
    send_triangle(flat_triangle(coord_t'(32'h7FFF_0000), MAX_COORD,
                                coord_t'(32'h7FFF_8001)));
    send_triangle(flat_triangle(coord_t'(32'hAAAA_AAAA), coord_t'(32'h5555_5555),
                                coord_t'(32'hAAAA_AAAA)));
    send_triangle(flat_triangle(coord_t'(32'h5555_5555), coord_t'(32'hAAAA_AAAA),
                                coord_t'(32'h5555_5555)));
    unit_tri = '0;
    unit_tri[3] = ONE_Q16;
    unit_tri[7] = ONE_Q16;
    unit_tri[8] = -ONE_Q16;
    send_triangle(unit_tri);
    stop_sending();
  endtask

  task automatic test_random_triangles();
    repeat (415) send_triangle(random_triangle());
    stop_sending();
  endtask

  // The output side holds off for a long stretch while triangles keep coming,
  // so the unit fills up and has to stall its input.
  task automatic test_output_hold();
    sender_gaps = 1'b0;
    hold_request = 1'b1;
    repeat (12) send_triangle(random_triangle());
    stop_sending();
    sender_gaps = 1'b1;
  endtask

  // Closing stretch with neither side idling, to check the gapless handover
  // from one triangle to the next at full rate.
  task automatic test_steady_stream();
    sender_gaps = 1'b0;
    stall_quiet = 1'b1;
    repeat (40) send_triangle(random_triangle());
    stop_sending();
  endtask

  // Output stall pattern: random bursts of stall and of free flow, the long
  // hold when a test asks for it, and nothing at all once the run goes quiet.
  initial begin
    wait (rst == 1'b0);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!stall_quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic compare_field(string name, coord_t want, coord_t got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Every point the unit hands over is checked against the oldest one owed.
  // Signals are read in the active region of the edge, before any of this
  // step's nonblocking updates land.
  always @(posedge clk) begin : check_points
    grid_point_t want;
    if (!rst && in_valid && in_stall) input_stall_cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected point, expected none, actual %h %h %h last %b",
                 $time, pt_x, pt_y, pt_z, last_point);
      end else begin
        want = pending_points.pop_front();
        compare_field("pt_x", want.x, pt_x);
        compare_field("pt_y", want.y, pt_y);
        compare_field("pt_z", want.z, pt_z);
        compare_field("last_point", coord_t'(want.last), coord_t'(last_point));
        points_checked++;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corner_triangles();
    test_random_triangles();
    test_output_hold();
    test_steady_stream();

    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d triangles and checked %0d grid points, covering extreme and",
             triangles_sent, points_checked);
    $display("clipped coordinates, random stalls and a long output hold (%0d input stalls).",
             input_stall_cycles);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
